>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the zero-run visibility decoder RTL.
// Each macro expects clk and rst_n in scope; assertions are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never hold.
`define AM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> hw/rtl/zrvd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the zero-run visibility decoder.
// No dependencies.
package zrvd_pkg;

  localparam int MAX_ROW_BYTES = 1024;
  localparam int LEAVES_W      = 14;
  localparam int ROW_LEN_W     = $clog2(MAX_ROW_BYTES) + 1;
  localparam int BYTE_W        = 8;
  localparam int OFFSET_W      = 10;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_LVL_W   = $clog2(QUEUE_DEPTH) + 1;

  // One run request from the front end to the run generator.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] count;
  } run_req_t;

  // Row length in bytes: ceil(leaves / 8), capped, with zero treated as one.
  function automatic logic [ROW_LEN_W-1:0] row_length(input logic [LEAVES_W-1:0] leaves);
    logic [LEAVES_W:0]     sum;
    logic [LEAVES_W-3:0]   len;
    logic [ROW_LEN_W-1:0]  res;
    sum = {1'b0, leaves} + (LEAVES_W + 1)'(7);
    len = sum[LEAVES_W:3];
    if (len > (LEAVES_W - 2)'(MAX_ROW_BYTES)) begin
      res = ROW_LEN_W'(MAX_ROW_BYTES);
    end else if (len == '0) begin
      res = ROW_LEN_W'(1);
    end else begin
      res = len[ROW_LEN_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/zrvd_front.sv
`timescale 1ns / 1ps
// Front end: accepts compressed bytes, tracks the zero-escape state and
// turns each byte into a run request. Depends on zrvd_pkg.
module zrvd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wen,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] code_byte
  input  logic                     q_ready,
  output logic                     q_push,
  output zrvd_pkg::run_req_t       q_data
);

  logic awaiting_r, awaiting_nxt;
  logic accept;
  logic zero_byte;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && in_tready;
  assign zero_byte = (in_tdata == '0);

  always_comb begin
    awaiting_nxt = awaiting_r;
    q_push       = 1'b0;
    q_data.value = in_tdata;
    q_data.count = zrvd_pkg::BYTE_W'(1);
    if (accept) begin
      if (awaiting_r) begin
        // count byte: zero count disarms with no run
        awaiting_nxt = 1'b0;
        q_push       = !zero_byte;
        q_data.value = '0;
        q_data.count = in_tdata;
      end else if (zero_byte) begin
        awaiting_nxt = 1'b1;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wen) begin
      awaiting_r <= 1'b0;
    end else begin
      awaiting_r <= awaiting_nxt;
    end
  end

endmodule

>>> hw/rtl/zrvd_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of run requests between the front end and the run generator.
// Depends on zrvd_pkg.
module zrvd_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  zrvd_pkg::run_req_t                    push_data,
  output logic                                  push_ready,
  input  logic                                  pop,
  output logic                                  head_valid,
  output zrvd_pkg::run_req_t                    head_data,
  output logic [zrvd_pkg::QUEUE_LVL_W-1:0]      level
);

  localparam int PTR_W = $clog2(zrvd_pkg::QUEUE_DEPTH);

  zrvd_pkg::run_req_t                    slot_r [zrvd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]                      wr_ptr_r, rd_ptr_r;
  logic [zrvd_pkg::QUEUE_LVL_W-1:0]      level_r, level_nxt;
  logic                                  do_push, do_pop;

  assign push_ready = (level_r != zrvd_pkg::QUEUE_LVL_W'(zrvd_pkg::QUEUE_DEPTH));
  assign head_valid = (level_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign level      = level_r;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    level_nxt = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/zrvd_back.sv
`timescale 1ns / 1ps
// Run generator: clips each request to the row, tracks the row offset and
// drives the registered result channel. Depends on zrvd_pkg.
module zrvd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wen,
  input  logic [13:0]              cfg_wdata,
  input  logic                     head_valid,
  input  zrvd_pkg::run_req_t       head_data,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [31:0]              out_tdata,  // [7:0] fill_value, [15:8] repeat_count,
                                               // [25:16] start_offset, [31:26] zero
  output logic                     out_tlast   // row_done
);

  localparam int RW = zrvd_pkg::ROW_LEN_W;

  logic [RW-1:0]                 row_len_r;
  logic [RW-1:0]                 written_r, written_nxt;
  logic                          valid_r;
  logic [zrvd_pkg::BYTE_W-1:0]   value_r, rep_r;
  logic [zrvd_pkg::OFFSET_W-1:0] offset_r;
  logic                          done_r;

  logic [RW-1:0] left;
  logic [RW-1:0] cnt_ext;
  logic [RW-1:0] rep;
  logic          done;

  assign pop = head_valid && (!valid_r || out_tready);

  always_comb begin
    left    = (written_r < row_len_r) ? (row_len_r - written_r) : RW'(1);
    cnt_ext = RW'(head_data.count);
    rep     = (cnt_ext < left) ? cnt_ext : left;
    done    = (rep == left);
    written_nxt = done ? '0 : (written_r + rep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= RW'(1);
      written_r <= '0;
      valid_r   <= 1'b0;
    end else if (cfg_wen) begin
      // new leaf count restarts the row
      row_len_r <= zrvd_pkg::row_length(cfg_wdata);
      written_r <= '0;
    end else begin
      if (pop) begin
        written_r <= written_nxt;
        valid_r   <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_r  <= head_data.value;
      rep_r    <= rep[zrvd_pkg::BYTE_W-1:0];
      offset_r <= written_r[zrvd_pkg::OFFSET_W-1:0];
      done_r   <= done;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, offset_r, rep_r, value_r};
  assign out_tlast  = done_r;

endmodule

>>> hw/rtl/zero_run_visibility_decoder_unit.sv
`timescale 1ns / 1ps
// Zero-run visibility row decoder, top level.
// A taken count or literal byte is stored in the queue, and its result is then registered
// in the output register. Throughput: one byte per cycle while out_tready holds, set by the run
// generator feeding one output register; a two-entry queue decouples byte intake from result drain.
// Reset (rst_n, synchronous): empty queue, no result, row offset 0, leaf count 1.
`include "assert_macros.svh"

module zero_run_visibility_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [13:0] cfg_wdata,   // num_leaves
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] code_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] fill_value, [15:8] repeat_count,
                                   // [25:16] start_offset, [31:26] zero
  output logic        out_tlast    // row_done
);

  logic                                  q_push, q_ready, q_pop, q_head_valid;
  zrvd_pkg::run_req_t                    q_push_data, q_head_data;
  logic [zrvd_pkg::QUEUE_LVL_W-1:0]      q_level;

  zrvd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  zrvd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .level      (q_level)
  );

  zrvd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `AM_ASSERT_NEVER(a_queue_overfill, q_level > zrvd_pkg::QUEUE_LVL_W'(zrvd_pkg::QUEUE_DEPTH), "run queue level beyond depth")
  `AM_ASSERT_IMPLY(a_repeat_nonzero, out_tvalid, out_tdata[15:8] != 8'd0, "run with zero repeat")
  `AM_ASSERT_IMPLY(a_literal_single, out_tvalid && (out_tdata[7:0] != 8'd0), out_tdata[15:8] == 8'd1, "literal run repeat not one")
  `AM_ASSERT_IMPLY(a_ready_tracks_queue, in_tready, q_level != zrvd_pkg::QUEUE_LVL_W'(zrvd_pkg::QUEUE_DEPTH), "input ready while queue full")

endmodule

>>> dv/zero_run_visibility_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the zero-run visibility row decoder. It streams compressed
// bytes, predicts each run descriptor and checks it against the output stream.
// Depends on zrvd_pkg and the zero_run_visibility_decoder_unit RTL.
module zero_run_visibility_decoder_unit_test;

  localparam int DRAIN_CYCLES      = 8;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int PHASE_SETTINGS    = 4;
  localparam int BYTES_PER_SETTING = 162;

  typedef struct packed {
    logic [zrvd_pkg::BYTE_W-1:0]   fill;
    logic [zrvd_pkg::BYTE_W-1:0]   reps;
    logic [zrvd_pkg::OFFSET_W-1:0] offset;
    logic                          done;
  } run_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_wen    = 1'b0;
  logic [zrvd_pkg::LEAVES_W-1:0] cfg_wdata  = '0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [31:0]                   out_tdata;
  logic                          out_tlast;

  logic [7:0]  byte_queue[$];
  run_t        pending_runs[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count  = 0;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  logic        in_taken     = 1'b0;

  // Predictor state
  logic [zrvd_pkg::LEAVES_W-1:0] row_leaves;
  logic                          count_armed;
  logic [10:0]                   row_fill;

  zero_run_visibility_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic emit_run(input logic [7:0] value, input logic [7:0] count);
    int unsigned len;
    int unsigned left;
    int unsigned rep;
    run_t        r;
    len = (int'(row_leaves) + 7) / 8;
    if (len > zrvd_pkg::MAX_ROW_BYTES) len = zrvd_pkg::MAX_ROW_BYTES;
    if (len == 0) len = 1;
    left = (row_fill < len) ? len - row_fill : 1;
    rep = (count < left) ? count : left;
    r.fill   = value;
    r.reps   = 8'(rep);
    r.offset = row_fill[zrvd_pkg::OFFSET_W-1:0];
    r.done   = (rep == left);
    pending_runs.push_back(r);
    row_fill = r.done ? 11'd0 : row_fill + 11'(rep);
  endtask

  task automatic decode_code_byte(input logic [7:0] code);
    if (count_armed) begin
      count_armed = 1'b0;
      if (code != 8'd0) emit_run(8'd0, code);
    end else if (code == 8'd0) begin
      count_armed = 1'b1;
    end else begin
      emit_run(code, 8'd1);
    end
  endtask

  // Driver: hold each byte until its transaction completes
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= out_idle_pct);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
      end
    end
  end

  // Monitor, predictor update and watchdog
  always @(posedge clk) begin
    run_t want;
    in_taken <= in_tvalid && in_tready;
    if (!rst_n) begin
      row_leaves  = zrvd_pkg::LEAVES_W'(1);
      count_armed = 1'b0;
      row_fill    = '0;
    end else if (cfg_wen) begin
      row_leaves  = cfg_wdata;
      count_armed = 1'b0;
      row_fill    = '0;
    end
    if (out_tvalid && out_tready) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected run, expected none, actual tdata %h last %b",
                 $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = pending_runs.pop_front();
        if (out_tdata !== {6'b0, want.offset, want.reps, want.fill} ||
            out_tlast !== want.done) begin
          $display("%0t: run mismatch, expected tdata %h last %b, actual tdata %h last %b",
                   $time, {6'b0, want.offset, want.reps, want.fill}, want.done,
                   out_tdata, out_tlast);
          error_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      bytes_taken++;
      decode_code_byte(in_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] code);
    byte_queue.push_back(code);
    bytes_queued++;
  endtask

  // Wait for every byte and run to drain, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (bytes_taken != bytes_queued || pending_runs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_leaves(input logic [zrvd_pkg::LEAVES_W-1:0] leaves);
    wait_idle();
    cfg_wen   = 1'b1;
    cfg_wdata = leaves;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  task automatic queue_random_token();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 48) begin
      queue_byte(8'($urandom_range(255, 1)));
    end else if (pick < 90) begin
      queue_byte(8'd0);
      pick = $urandom_range(99, 0);
      if (pick < 10) queue_byte(8'd0);
      else if (pick < 25) queue_byte(8'd255);
      else if (pick < 35) queue_byte(8'd1);
      else if (pick < 60) queue_byte(8'($urandom_range(8, 1)));
      else queue_byte(8'($urandom_range(255, 1)));
    end else begin
      // stray zero: the first byte of the next token becomes its count
      queue_byte(8'd0);
    end
  endtask

  initial begin
    int unsigned                   target;
    logic [zrvd_pkg::LEAVES_W-1:0] leaves;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n        = 1'b1;
    in_idle_pct  = 38;
    out_idle_pct = 61;

    // Leaf count from reset: one-byte rows, every run completes the row
    queue_byte(8'hFF);
    queue_byte(8'h00); queue_byte(8'h05);   // clip to the single byte left
    queue_byte(8'h00); queue_byte(8'h00);   // count of zero gives no run

    program_leaves(14'd40);                 // five-byte rows
    queue_byte(8'h80);
    queue_byte(8'h00); queue_byte(8'h02);
    queue_byte(8'h7F);
    queue_byte(8'h00); queue_byte(8'hFF);   // clip to the last byte
    queue_byte(8'h55);
    queue_byte(8'h00); queue_byte(8'h04);   // exactly reaches the row end
    queue_byte(8'h00);                      // leave a count armed across the write

    program_leaves(14'd0);                  // zero leaf count acts as one byte
    queue_byte(8'h2A);                      // literal, since the write disarmed
    queue_byte(8'h00); queue_byte(8'hAA);

    program_leaves(14'h3FFF);               // capped at the longest row
    repeat (4) begin
      queue_byte(8'h00); queue_byte(8'hFF);
    end
    queue_byte(8'h00); queue_byte(8'h09);   // clip to the last four bytes

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 38 : (phase == 1) ? 61 : 0;
      out_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 38 : 0;
      for (int s = 0; s < PHASE_SETTINGS; s++) begin
        case ($urandom_range(7, 0))
          0:       leaves = '0;
          1:       leaves = zrvd_pkg::LEAVES_W'(1);
          2:       leaves = zrvd_pkg::LEAVES_W'(8192);
          3:       leaves = '1;
          4:       leaves = zrvd_pkg::LEAVES_W'($urandom_range(64, 2));
          5, 6:    leaves = zrvd_pkg::LEAVES_W'($urandom_range(2000, 65));
          default: leaves = zrvd_pkg::LEAVES_W'($urandom);
        endcase
        program_leaves(leaves);
        target = bytes_queued + BYTES_PER_SETTING;
        while (bytes_queued < target) queue_random_token();
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
